[hdl/round_robin_task_scheduler_macros.svh]
// Assertion helpers used by the scheduler top level.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rrts_pkg.sv]
package rrts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int DATA_W = 16;
	localparam logic [DATA_W-1:0] QUANTUM_RST = 16'd2;

	typedef enum logic [1:0] {
		OUT_NONE     = 2'd0,
		OUT_REQUEUED = 2'd1,
		OUT_FINISHED = 2'd2,
		OUT_BLOCKED  = 2'd3
	} outcome_t;

	typedef enum logic {
		REQ_ADD   = 1'b0,
		REQ_CYCLE = 1'b1
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] remaining;
		logic [DATA_W-1:0] turns;
	} entry_t;

	typedef struct packed {
		logic              add_accepted;
		logic              ran_valid;
		logic [DATA_W-1:0] ran_task_id;
		logic [DATA_W-1:0] ran_remaining;
		logic [DATA_W-1:0] ran_turns;
		outcome_t          outcome;
		logic              woken_valid;
		logic [DATA_W-1:0] woken_task_id;
		logic [CNT_W-1:0]  ready_count;
		logic [CNT_W-1:0]  blocked_count;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic exec;
		logic wb;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_wb;
		logic out_free;
	} status_t;

	// ring index wrap, input is below 2*MAX_TASKS
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] d;
		d = s - SUM_W'(MAX_TASKS);
		return (s >= SUM_W'(MAX_TASKS)) ? d[IDX_W-1:0] : s[IDX_W-1:0];
	endfunction

endpackage

[hdl/rrts_ctrl.sv]
module rrts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrts_pkg::status_t   status,
	output rrts_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WB,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	always_comb begin
		cmd = '0;
		cmd.accept   = in_valid && in_ready_q;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.wb       = (state_q == ST_WB);
		cmd.load_out = (state_q == ST_OUT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					state_q <= status.need_wb ? ST_WB : ST_OUT;
				end
				ST_WB: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (status.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

[hdl/rrts_dp.sv]
module rrts_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rrts_pkg::cmd_t                     cmd,
	output rrts_pkg::status_t                  status,
	input  logic                               cfg_valid,
	input  logic [rrts_pkg::DATA_W-1:0]        cfg_data,
	input  logic                               req_type,
	input  logic [rrts_pkg::DATA_W-1:0]        task_id,
	input  logic [rrts_pkg::DATA_W-1:0]        burst_time,
	input  logic                               wake_request,
	input  logic                               block_request,
	output logic                               out_valid,
	input  logic                               out_ready,
	output rrts_pkg::result_t                  result
);

	localparam int IDX_W = rrts_pkg::IDX_W;
	localparam int CNT_W = rrts_pkg::CNT_W;
	localparam int SUM_W = rrts_pkg::SUM_W;
	localparam int DATA_W = rrts_pkg::DATA_W;

	rrts_pkg::entry_t ready_mem [rrts_pkg::MAX_TASKS];
	rrts_pkg::entry_t blocked_mem [rrts_pkg::MAX_TASKS];

	logic [DATA_W-1:0] quantum_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  rfill_q;
	logic [CNT_W-1:0]  bfill_q;

	// latched request
	logic              req_q;
	logic [DATA_W-1:0] id_q;
	logic [DATA_W-1:0] burst_q;
	logic              blk_q;
	logic              wake_ok_q;

	rrts_pkg::entry_t rd_ready_q;
	rrts_pkg::entry_t rd_blk_q;
	rrts_pkg::entry_t wb_entry_q;
	logic [IDX_W-1:0] wb_idx_q;

	rrts_pkg::result_t res_q;
	rrts_pkg::result_t out_q;
	logic              out_valid_q;

	logic [CNT_W-1:0]  bfill_m1;
	logic              wake_ok;

	// execute-stage logic
	logic              is_add;
	logic              add_ok;
	logic              woke;
	logic [CNT_W-1:0]  fill1;
	logic              run;
	rrts_pkg::entry_t  cur;
	rrts_pkg::entry_t  upd;
	logic              finished;
	logic [CNT_W-1:0]  bfill1;
	logic              do_block;
	logic              requeue;
	logic [IDX_W-1:0]  tail0;
	logic [IDX_W-1:0]  tail1;
	logic [IDX_W-1:0]  head_nxt;
	logic [CNT_W-1:0]  rfill_nxt;
	logic [CNT_W-1:0]  bfill_nxt;
	logic              rwe;
	logic [IDX_W-1:0]  rwaddr;
	rrts_pkg::entry_t  rwdata;
	rrts_pkg::entry_t  add_entry;
	rrts_pkg::entry_t  woken_entry;
	rrts_pkg::result_t res_d;

	assign bfill_m1 = bfill_q - CNT_W'(1);
	assign wake_ok  = (req_type == rrts_pkg::REQ_CYCLE) && wake_request
		&& (bfill_q != '0) && (rfill_q != CNT_W'(rrts_pkg::MAX_TASKS));

	always_comb begin
		is_add   = (req_q == rrts_pkg::REQ_ADD);
		add_ok   = is_add && (rfill_q != CNT_W'(rrts_pkg::MAX_TASKS));
		woke     = !is_add && wake_ok_q;
		fill1    = rfill_q + CNT_W'(woke);
		run      = !is_add && (fill1 != '0);
		// with an empty queue the woken task is the one that runs
		cur      = (woke && (rfill_q == '0)) ? rd_blk_q : rd_ready_q;
		upd.id        = cur.id;
		upd.remaining = (cur.remaining > quantum_q) ? cur.remaining - quantum_q : '0;
		upd.turns     = (cur.turns != '1) ? cur.turns + DATA_W'(1) : cur.turns;
		finished = (upd.remaining == '0);
		bfill1   = bfill_q - CNT_W'(woke);
		do_block = run && !finished && blk_q
			&& (bfill1 != CNT_W'(rrts_pkg::MAX_TASKS));
		requeue  = run && !finished && !do_block;
		tail0    = rrts_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(rfill_q));
		tail1    = rrts_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(rfill_q) + SUM_W'(1));
		head_nxt = run ? rrts_pkg::wrap_idx(SUM_W'(head_q) + SUM_W'(1)) : head_q;
		if (is_add) begin
			rfill_nxt = rfill_q + CNT_W'(add_ok);
		end else begin
			rfill_nxt = fill1 - CNT_W'(run) + CNT_W'(requeue);
		end
		bfill_nxt = bfill1 + CNT_W'(do_block);

		add_entry.id        = id_q;
		add_entry.remaining = burst_q;
		add_entry.turns     = '0;
		woken_entry         = rd_blk_q;

		rwe    = 1'b0;
		rwaddr = tail0;
		rwdata = add_entry;
		if (cmd.exec) begin
			priority if (is_add) begin
				rwe    = add_ok;
				rwdata = add_entry;
			end else if (woke) begin
				rwe    = 1'b1;
				rwdata = woken_entry;
			end else begin
				rwe    = requeue;
				rwdata = upd;
			end
		end else if (cmd.wb) begin
			rwe    = 1'b1;
			rwaddr = wb_idx_q;
			rwdata = wb_entry_q;
		end

		res_d = '0;
		res_d.add_accepted  = add_ok;
		res_d.ran_valid     = run;
		res_d.woken_valid   = woke;
		res_d.ready_count   = rfill_nxt;
		res_d.blocked_count = bfill_nxt;
		res_d.outcome       = rrts_pkg::OUT_NONE;
		if (woke) begin
			res_d.woken_task_id = rd_blk_q.id;
		end
		if (run) begin
			res_d.ran_task_id   = upd.id;
			res_d.ran_remaining = upd.remaining;
			res_d.ran_turns     = upd.turns;
			priority if (finished) begin
				res_d.outcome = rrts_pkg::OUT_FINISHED;
			end else if (do_block) begin
				res_d.outcome = rrts_pkg::OUT_BLOCKED;
			end else begin
				res_d.outcome = rrts_pkg::OUT_REQUEUED;
			end
		end
	end

	assign status.need_wb  = woke && requeue;
	assign status.out_free = !out_valid_q || out_ready;

	// memories
	always_ff @(posedge clk) begin
		if (rwe) begin
			ready_mem[rwaddr] <= rwdata;
		end
		if (cmd.accept) begin
			rd_ready_q <= ready_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_block) begin
			blocked_mem[bfill1[IDX_W-1:0]] <= upd;
		end
		if (cmd.accept) begin
			rd_blk_q <= blocked_mem[bfill_m1[IDX_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= req_type;
			id_q      <= task_id;
			burst_q   <= burst_time;
			blk_q     <= block_request;
			wake_ok_q <= wake_ok;
		end
		if (cmd.exec) begin
			res_q      <= res_d;
			wb_entry_q <= upd;
			wb_idx_q   <= tail1;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q   <= rrts_pkg::QUANTUM_RST;
			head_q      <= '0;
			rfill_q     <= '0;
			bfill_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				quantum_q <= cfg_data;
			end
			if (cmd.exec) begin
				head_q  <= head_nxt;
				rfill_q <= rfill_nxt;
				bfill_q <= bfill_nxt;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

[hdl/round_robin_task_scheduler.sv]
// Channel   Handshake             Word
// cfg       cfg_valid/cfg_ready   cfg_data (quantum)
// in        in_valid/in_ready     req_type, task_id, burst_time, wake_request, block_request
// out       out_valid/out_ready   add_accepted ... blocked_count
//
// One item at a time, in order: accept (queue head and stack top read), execute,
// a write-back step only when a cycle item both wakes and requeues (single ready
// memory write port), then loading the output register.
// in_ready drops after accept and returns once the result sits in the output register.
// A stalled out_ready holds the block in its output step.
// Reset: queue and stack empty, quantum 2; no clearing pass. cfg_ready is always high.
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rrts_pkg::DATA_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic [rrts_pkg::DATA_W-1:0]         task_id,
	input  logic [rrts_pkg::DATA_W-1:0]         burst_time,
	input  logic                                wake_request,
	input  logic                                block_request,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                add_accepted,
	output logic                                ran_valid,
	output logic [rrts_pkg::DATA_W-1:0]         ran_task_id,
	output logic [rrts_pkg::DATA_W-1:0]         ran_remaining,
	output logic [rrts_pkg::DATA_W-1:0]         ran_turns,
	output logic [1:0]                          outcome,
	output logic                                woken_valid,
	output logic [rrts_pkg::DATA_W-1:0]         woken_task_id,
	output logic [rrts_pkg::CNT_W-1:0]          ready_count,
	output logic [rrts_pkg::CNT_W-1:0]          blocked_count
);

	rrts_pkg::cmd_t    cmd;
	rrts_pkg::status_t status;
	rrts_pkg::result_t result;

	assign cfg_ready = 1'b1;

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rrts_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.task_id       (task_id),
		.burst_time    (burst_time),
		.wake_request  (wake_request),
		.block_request (block_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (result)
	);

	assign add_accepted  = result.add_accepted;
	assign ran_valid     = result.ran_valid;
	assign ran_task_id   = result.ran_task_id;
	assign ran_remaining = result.ran_remaining;
	assign ran_turns     = result.ran_turns;
	assign outcome       = result.outcome;
	assign woken_valid   = result.woken_valid;
	assign woken_task_id = result.woken_task_id;
	assign ready_count   = result.ready_count;
	assign blocked_count = result.blocked_count;

	`RRTS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "second word taken while busy")
	`RRTS_ASSERT_IMPL(a_outcome_ran, clk, arst_n, out_valid && (outcome != rrts_pkg::OUT_NONE), ran_valid, "outcome without a run")
	`RRTS_ASSERT_IMPL(a_add_no_run, clk, arst_n, out_valid && add_accepted, !ran_valid && !woken_valid, "add word reports a run")
	`RRTS_ASSERT_IMPL(a_block_count, clk, arst_n, out_valid && (outcome == rrts_pkg::OUT_BLOCKED), blocked_count != '0, "blocked with empty stack")

endmodule

[test/round_robin_task_scheduler_test.sv]
module round_robin_task_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [rrts_pkg::DATA_W-1:0] word_t;

	// Tracks the ready ring and the blocked stack from accepted words and
	// holds the result words still owed by the block.
	class schedule_tracker;
		rrts_pkg::entry_t ready_mem[rrts_pkg::MAX_TASKS];
		rrts_pkg::entry_t blocked_mem[rrts_pkg::MAX_TASKS];
		int ready_head;
		int ready_fill;
		int blocked_fill;
		word_t quantum;
		rrts_pkg::result_t pending_results[$];
		int errors;

		function new();
			ready_head = 0;
			ready_fill = 0;
			blocked_fill = 0;
			quantum = rrts_pkg::QUANTUM_RST;
			errors = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void ready_append(rrts_pkg::entry_t e);
			ready_mem[(ready_head + ready_fill) % rrts_pkg::MAX_TASKS] = e;
			ready_fill++;
		endfunction

		function void note_request(rrts_pkg::req_t req, word_t id,
				word_t burst, logic wake, logic blk);
			rrts_pkg::result_t r;
			rrts_pkg::entry_t e;
			r = '0;
			if (req == rrts_pkg::REQ_ADD) begin
				if (ready_fill < rrts_pkg::MAX_TASKS) begin
					e.id = id;
					e.remaining = burst;
					e.turns = '0;
					ready_append(e);
					r.add_accepted = 1'b1;
				end
			end else begin
				if (wake && blocked_fill > 0 && ready_fill < rrts_pkg::MAX_TASKS) begin
					blocked_fill--;
					e = blocked_mem[blocked_fill];
					ready_append(e);
					r.woken_valid = 1'b1;
					r.woken_task_id = e.id;
				end
				if (ready_fill > 0) begin
					e = ready_mem[ready_head];
					ready_head = (ready_head + 1) % rrts_pkg::MAX_TASKS;
					ready_fill--;
					e.remaining = (e.remaining > quantum) ? e.remaining - quantum : '0;
					if (e.turns != 16'hFFFF)
						e.turns = e.turns + 1'b1;
					r.ran_valid = 1'b1;
					r.ran_task_id = e.id;
					r.ran_remaining = e.remaining;
					r.ran_turns = e.turns;
					if (e.remaining == 0) begin
						r.outcome = rrts_pkg::OUT_FINISHED;
					end else if (blk && blocked_fill < rrts_pkg::MAX_TASKS) begin
						blocked_mem[blocked_fill] = e;
						blocked_fill++;
						r.outcome = rrts_pkg::OUT_BLOCKED;
					end else begin
						ready_append(e);
						r.outcome = rrts_pkg::OUT_REQUEUED;
					end
				end
			end
			r.ready_count = rrts_pkg::CNT_W'(ready_fill);
			r.blocked_count = rrts_pkg::CNT_W'(blocked_fill);
			pending_results.push_back(r);
		endfunction

		function void diff(string name, word_t want, word_t got);
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on %s: expected %h, got %h", name, want, got);
			end
		endfunction

		function void check_result(rrts_pkg::result_t got);
			rrts_pkg::result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result word with nothing expected: %p", got);
				return;
			end
			want = pending_results.pop_front();
			diff("add_accepted", word_t'(want.add_accepted), word_t'(got.add_accepted));
			diff("ran_valid", word_t'(want.ran_valid), word_t'(got.ran_valid));
			diff("ran_task_id", want.ran_task_id, got.ran_task_id);
			diff("ran_remaining", want.ran_remaining, got.ran_remaining);
			diff("ran_turns", want.ran_turns, got.ran_turns);
			diff("outcome", word_t'(want.outcome), word_t'(got.outcome));
			diff("woken_valid", word_t'(want.woken_valid), word_t'(got.woken_valid));
			diff("woken_task_id", want.woken_task_id, got.woken_task_id);
			diff("ready_count", word_t'(want.ready_count), word_t'(got.ready_count));
			diff("blocked_count", word_t'(want.blocked_count), word_t'(got.blocked_count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	word_t task_id = '0;
	word_t burst_time = '0;
	logic wake_request = 1'b0;
	logic block_request = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic add_accepted;
	logic ran_valid;
	word_t ran_task_id;
	word_t ran_remaining;
	word_t ran_turns;
	logic [1:0] outcome;
	logic woken_valid;
	word_t woken_task_id;
	logic [rrts_pkg::CNT_W-1:0] ready_count;
	logic [rrts_pkg::CNT_W-1:0] blocked_count;

	// no idling on either side while set
	bit calm = 1'b0;
	schedule_tracker tracker = new();

	round_robin_task_scheduler u_dut (.*);

	always #10 clk = ~clk;

	initial begin
		#100ms;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: checks every accepted result word, idles at random, and once
	// holds off long enough to stall the input side
	initial begin
		rrts_pkg::result_t got;
		int words_seen;
		int hold;
		words_seen = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.add_accepted = add_accepted;
				got.ran_valid = ran_valid;
				got.ran_task_id = ran_task_id;
				got.ran_remaining = ran_remaining;
				got.ran_turns = ran_turns;
				got.outcome = rrts_pkg::outcome_t'(outcome);
				got.woken_valid = woken_valid;
				got.woken_task_id = woken_task_id;
				got.ready_count = ready_count;
				got.blocked_count = blocked_count;
				tracker.check_result(got);
				words_seen++;
				if (words_seen == 600)
					hold = 400;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 36);
			end
		end
	end

	task automatic push_item(input rrts_pkg::req_t req, input word_t id,
			input word_t burst, input logic wake, input logic blk);
		if (!calm && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 36);
		end
		in_valid <= 1'b1;
		req_type <= req;
		task_id <= id;
		burst_time <= burst;
		wake_request <= wake;
		block_request <= blk;
		do @(posedge clk); while (!in_ready);
		tracker.note_request(req, id, burst, wake, blk);
	endtask

	task automatic write_quantum(input word_t q);
		cfg_valid <= 1'b1;
		cfg_data <= q;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.quantum = q;
	endtask

	// sender stops until every owed result word has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// run cycles with wake until both ready ring and stack are empty
	// (meant for a quantum large enough that every turn finishes)
	task automatic flush_tasks();
		while (tracker.ready_fill + tracker.blocked_fill > 0)
			push_item(rrts_pkg::REQ_CYCLE, 16'($urandom), 16'($urandom), 1'b1, 1'b0);
	endtask

	function automatic word_t pick_burst();
		case ($urandom_range(0, 3))
			0, 1: return 16'($urandom_range(0, 8));
			2: return 16'($urandom_range(0, 64));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_phase(input int n, input int add_pct, input int wake_pct,
			input int blk_pct);
		rrts_pkg::req_t req;
		for (int k = 0; k < n; k++) begin
			req = ($urandom_range(0, 99) < add_pct) ? rrts_pkg::REQ_ADD : rrts_pkg::REQ_CYCLE;
			push_item(req, 16'($urandom), pick_burst(),
				$urandom_range(0, 99) < wake_pct, $urandom_range(0, 99) < blk_pct);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// quantum at its reset value
		push_item(rrts_pkg::REQ_CYCLE, 16'h5555, 16'h5555, 1'b1, 1'b1);	// idle, wake on empty stack
		push_item(rrts_pkg::REQ_ADD, 16'h0000, 16'h0000, 1'b1, 1'b1);
		push_item(rrts_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
		push_item(rrts_pkg::REQ_ADD, 16'h1234, 16'h0003, 1'b1, 1'b0);
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b0, 1'b0);	// zero burst finishes
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b0, 1'b1);	// blocked
		push_item(rrts_pkg::REQ_CYCLE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);	// one woken, the head requeued
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b0, 1'b0);
		settle();
		write_quantum(16'h0000);
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b0, 1'b0);
		push_item(rrts_pkg::REQ_ADD, 16'h00FF, 16'h0000, 1'b0, 1'b0);
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b0, 1'b1);
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b1, 1'b0);
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b0, 1'b0);
		push_item(rrts_pkg::REQ_CYCLE, 16'h0000, 16'h0000, 1'b1, 1'b1);
		settle();
		write_quantum(16'hFFFF);
		flush_tasks();

		// one task kept cycling at zero quantum, no idling on either side
		settle();
		write_quantum(16'h0000);
		calm = 1'b1;
		push_item(rrts_pkg::REQ_ADD, 16'hA5A5, 16'h0001, 1'b0, 1'b0);
		repeat (40)
			push_item(rrts_pkg::REQ_CYCLE, 16'($urandom), 16'($urandom), 1'b1, 1'($urandom));
		settle();
		write_quantum(16'hFFFF);
		flush_tasks();

		settle();
		write_quantum(16'h0001);
		random_phase(250, 55, 30, 50);
		calm = 1'b0;
		settle();
		write_quantum(16'h0000);
		random_phase(250, 60, 20, 60);
		settle();
		write_quantum(16'h0003);
		random_phase(250, 40, 60, 30);
		settle();
		write_quantum(16'hFFFF);
		random_phase(250, 50, 50, 50);
		settle();
		write_quantum(16'($urandom_range(1, 16)));
		random_phase(250, 65, 40, 70);
		settle();
		write_quantum(16'($urandom_range(1, 65535)));
		random_phase(250, 45, 50, 50);
		settle();
		write_quantum(rrts_pkg::QUANTUM_RST);
		random_phase(250, 50, 45, 45);

		settle();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
